>>> hdl/ddcs_pkg.sv
package ddcs_pkg;

  localparam int QUEUE_DEPTH = 4;

  // driver register addresses
  localparam logic [3:0] ADDR_DIGIT1   = 4'd1;
  localparam logic [3:0] ADDR_DIGIT2   = 4'd2;
  localparam logic [3:0] ADDR_DIGIT3   = 4'd3;
  localparam logic [3:0] ADDR_DIGIT4   = 4'd4;
  localparam logic [3:0] ADDR_DECODE   = 4'd9;
  localparam logic [3:0] ADDR_SCAN     = 4'd11;
  localparam logic [3:0] ADDR_SHUTDOWN = 4'd12;

  localparam logic [7:0] DATA_NORMAL_OP = 8'h01;
  localparam logic [7:0] DATA_NO_DECODE = 8'h00;
  localparam logic [7:0] DATA_SCAN_4    = 8'h03;
  localparam logic [7:0] SEG_DASH       = 8'h01;
  localparam logic [7:0] SEG_E          = 8'h4F;
  localparam logic [7:0] SEG_R          = 8'h05;
  localparam logic [7:0] DP_BIT         = 8'h80;

  localparam logic [14:0] VALUE_MAX = 15'd9999;

  typedef struct packed {
    logic       err;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } item_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'h7E;
      4'd1: code = 8'h30;
      4'd2: code = 8'h6D;
      4'd3: code = 8'h79;
      4'd4: code = 8'h33;
      4'd5: code = 8'h5B;
      4'd6: code = 8'h5F;
      4'd7: code = 8'h70;
      4'd8: code = 8'h7F;
      4'd9: code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/decimal_display_command_sequencer_top.sv
// The first command word is strobed after s1, s2 and s3, the queue and the output register;
// the seventh carries last. The sequencer sends one word per cycle while the queue is not
// empty; up to QueueDepth values are buffered, so start is taken while earlier runs go on.
// The receiver cannot stall: each word is presented for one cycle with strobe high.
// Reset (rst, synchronous): empties the digit pipeline and queue and restarts the sequencer.
module decimal_display_command_sequencer_top #(
  parameter int QueueDepth = ddcs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] value,
  output logic               strobe,
  output logic [3:0]         reg_address,
  output logic [7:0]         reg_data,
  output logic               last
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic            push, pop, empty;
  ddcs_pkg::item_t push_item, head;
  logic [CntW-1:0] q_count;

  ddcs_front #(.Depth(QueueDepth)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  ddcs_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .empty     (empty),
    .count     (q_count),
    .head      (head)
  );

  ddcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .strobe      (strobe),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .last        (last)
  );

endmodule

>>> hdl/ddcs_front.sv
module ddcs_front #(
  parameter int Depth = ddcs_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [15:0]           value,
  output logic                         busy,
  input  logic [$clog2(Depth+1)-1:0]   q_count,
  output logic                         push,
  output ddcs_pkg::item_t              push_item
);

  localparam int OccW = $clog2(Depth + 4);

  logic s1_valid, s2_valid, s3_valid;
  logic s1_err, s2_err, s3_err;
  logic [13:0] s1_mag;
  logic [3:0]  s2_th, s3_th, s3_hu;
  logic [9:0]  s2_rem;
  logic [6:0]  s3_rem;

  logic        accept;
  logic        in_range;
  logic [OccW-1:0] occ;

  logic [27:0] prod_th;
  logic [3:0]  th;
  logic [13:0] th_x, th_scaled, rem_th;
  logic [22:0] prod_hu;
  logic [3:0]  hu;
  logic [9:0]  hu_x, hu_scaled, rem_hu;
  logic [14:0] prod_te;
  logic [3:0]  te;
  logic [6:0]  te_x, te_scaled, rem_te;

  // every transaction in the pipe or the queue holds a slot until popped
  assign occ = OccW'(q_count) + OccW'(s1_valid) + OccW'(s2_valid) + OccW'(s3_valid);
  assign busy = (occ >= OccW'(Depth));
  assign accept = start && !busy;

  assign in_range = !value[15] && (value != 16'sd0) && (value[14:0] <= ddcs_pkg::VALUE_MAX);

  // digit extraction by reciprocal multiply, exact for the valid range
  assign prod_th   = 28'(s1_mag) * 28'd8389;
  assign th        = prod_th[26:23];
  assign th_x      = {10'b0, th};
  assign th_scaled = (th_x << 10) - (th_x << 5) + (th_x << 3);
  assign rem_th    = s1_mag - th_scaled;

  assign prod_hu   = 23'(s2_rem) * 23'd5243;
  assign hu        = prod_hu[22:19];
  assign hu_x      = {6'b0, hu};
  assign hu_scaled = (hu_x << 6) + (hu_x << 5) + (hu_x << 2);
  assign rem_hu    = s2_rem - hu_scaled;

  assign prod_te   = 15'(s3_rem) * 15'd205;
  assign te        = prod_te[14:11];
  assign te_x      = {3'b0, te};
  assign te_scaled = (te_x << 3) + (te_x << 1);
  assign rem_te    = s3_rem - te_scaled;

  assign push                = s3_valid;
  assign push_item.err       = s3_err;
  assign push_item.thousands = s3_th;
  assign push_item.hundreds  = s3_hu;
  assign push_item.tens      = te;
  assign push_item.units     = rem_te[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err <= !in_range;
      s1_mag <= value[13:0];
    end
    s2_err <= s1_err;
    s2_th  <= th;
    s2_rem <= rem_th[9:0];
    s3_err <= s2_err;
    s3_th  <= s2_th;
    s3_hu  <= hu;
    s3_rem <= rem_hu[6:0];
  end

endmodule

>>> hdl/ddcs_queue.sv
module ddcs_queue #(
  parameter int Depth = ddcs_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  ddcs_pkg::item_t              push_item,
  input  logic                         pop,
  output logic                         empty,
  output logic [$clog2(Depth+1)-1:0]   count,
  output ddcs_pkg::item_t              head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ddcs_pkg::item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;

  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/ddcs_back.sv
module ddcs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  ddcs_pkg::item_t head,
  output logic            pop,
  output logic            strobe,
  output logic [3:0]      reg_address,
  output logic [7:0]      reg_data,
  output logic            last
);

  localparam logic [2:0] WORD_SHUTDOWN = 3'd0;
  localparam logic [2:0] WORD_DECODE   = 3'd1;
  localparam logic [2:0] WORD_SCAN     = 3'd2;
  localparam logic [2:0] WORD_DIGIT1   = 3'd3;
  localparam logic [2:0] WORD_DIGIT2   = 3'd4;
  localparam logic [2:0] WORD_DIGIT3   = 3'd5;
  localparam logic [2:0] WORD_DIGIT4   = 3'd6;

  logic [2:0] idx;
  logic       active;
  logic [3:0] addr_next;
  logic [7:0] data_next;

  assign active = !empty;
  assign pop    = active && (idx == WORD_DIGIT4);

  always_comb begin
    addr_next = ddcs_pkg::ADDR_SHUTDOWN;
    data_next = ddcs_pkg::DATA_NORMAL_OP;
    case (idx)
      WORD_SHUTDOWN: begin
        addr_next = ddcs_pkg::ADDR_SHUTDOWN;
        data_next = ddcs_pkg::DATA_NORMAL_OP;
      end
      WORD_DECODE: begin
        addr_next = ddcs_pkg::ADDR_DECODE;
        data_next = ddcs_pkg::DATA_NO_DECODE;
      end
      WORD_SCAN: begin
        addr_next = ddcs_pkg::ADDR_SCAN;
        data_next = ddcs_pkg::DATA_SCAN_4;
      end
      WORD_DIGIT1: begin
        addr_next = ddcs_pkg::ADDR_DIGIT1;
        data_next = head.err ? ddcs_pkg::SEG_DASH
                             : (ddcs_pkg::seg_of(head.thousands) | ddcs_pkg::DP_BIT);
      end
      WORD_DIGIT2: begin
        addr_next = ddcs_pkg::ADDR_DIGIT2;
        data_next = head.err ? ddcs_pkg::SEG_E : ddcs_pkg::seg_of(head.hundreds);
      end
      // error pattern writes digit 4 before digit 3
      WORD_DIGIT3: begin
        addr_next = head.err ? ddcs_pkg::ADDR_DIGIT4 : ddcs_pkg::ADDR_DIGIT3;
        data_next = head.err ? ddcs_pkg::SEG_R : ddcs_pkg::seg_of(head.tens);
      end
      WORD_DIGIT4: begin
        addr_next = head.err ? ddcs_pkg::ADDR_DIGIT3 : ddcs_pkg::ADDR_DIGIT4;
        data_next = head.err ? ddcs_pkg::SEG_R : ddcs_pkg::seg_of(head.units);
      end
      default: begin
        addr_next = ddcs_pkg::ADDR_SHUTDOWN;
        data_next = ddcs_pkg::DATA_NORMAL_OP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= WORD_SHUTDOWN;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        idx <= (idx == WORD_DIGIT4) ? WORD_SHUTDOWN : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    reg_address <= addr_next;
    reg_data    <= data_next;
    last        <= (idx == WORD_DIGIT4);
  end

endmodule
